// ----- hdl/tbwc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package tbwc_pkg;

  localparam int unsigned TAG_W   = 32;
  localparam int unsigned BYTES_W = 32;
  localparam int unsigned CNT_W   = 24;
  localparam int unsigned SPAN_W  = 16;
  localparam int unsigned LIMIT_W = 5;
  localparam int unsigned USED_W  = 5;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SPAN  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECORD_LIMIT = 1'd1;

  localparam logic [SPAN_W-1:0]  SPAN_RESET  = 16'd15;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  localparam logic [BYTES_W-1:0] SAT_MAX = {BYTES_W{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_SUM,
    ST_FINISH
  } state_t;

  // per-cycle commands broadcast to every cell
  typedef struct packed {
    logic shift;
    logic add;
  } cell_ctrl_t;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [BYTES_W-1:0] bytes;
  } record_t;

  function automatic logic [BYTES_W-1:0] sat_add(input logic [BYTES_W-1:0] a,
                                                 input logic [BYTES_W-1:0] b);
    logic [BYTES_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[BYTES_W] ? SAT_MAX : s[BYTES_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- hdl/tbwc_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface tbwc_in_if;
  logic                       valid;
  logic                       ready;
  logic [tbwc_pkg::TAG_W-1:0] time_bucket;
  logic [tbwc_pkg::CNT_W-1:0] byte_count;

  modport source (output valid, output time_bucket, output byte_count, input ready);
  modport sink   (input valid, input time_bucket, input byte_count, output ready);
endinterface
`default_nettype wire

// ----- hdl/tbwc_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface tbwc_out_if;
  logic                         valid;
  logic                         ready;
  logic [tbwc_pkg::BYTES_W-1:0] window_bytes;
  logic [tbwc_pkg::USED_W-1:0]  records_used;

  modport source (output valid, output window_bytes, output records_used, input ready);
  modport sink   (input valid, input window_bytes, input records_used, output ready);
endinterface
`default_nettype wire

// ----- hdl/tbwc_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tbwc_cell (
  input  wire                            clk,
  input  wire tbwc_pkg::cell_ctrl_t      ctrl,
  input  wire tbwc_pkg::record_t         rec_in,
  output tbwc_pkg::record_t              rec_out,
  input  wire                            held,
  input  wire [tbwc_pkg::TAG_W-1:0]      bucket,
  input  wire [tbwc_pkg::SPAN_W-1:0]     span,
  input  wire [tbwc_pkg::BYTES_W-1:0]    add_bytes,
  input  wire [tbwc_pkg::BYTES_W-1:0]    psum_in,
  output logic [tbwc_pkg::BYTES_W-1:0]   psum_out
);
  import tbwc_pkg::*;

  record_t            rec;
  logic [BYTES_W-1:0] contrib;
  logic               in_window;

  // tag >= bucket - span, evaluated without wrap
  assign in_window = ({1'b0, rec.tag} + {{(TAG_W-SPAN_W+1){1'b0}}, span})
                     >= {1'b0, bucket};

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      rec <= rec_in;
    end else if (ctrl.add) begin
      rec.bytes <= sat_add(rec.bytes, add_bytes);
    end
    contrib  <= (held && in_window) ? rec.bytes : '0;
    psum_out <= sat_add(psum_in, contrib);
  end

  assign rec_out = rec;

endmodule
`default_nettype wire

// ----- hdl/time_bucket_window_byte_counter.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  Handshake     Payload
// in_ch    in   valid/ready   time_bucket[31:0], byte_count[23:0]
// out_ch   out  valid/ready   window_bytes[31:0], records_used[4:0]
// cfg      in   cfg_we        cfg_index[0:0], cfg_data[15:0] (0: window_span, 1: record_limit)
//
// Same bucket as the newest record: the transaction is accepted, then updated.
// New bucket: accept and shift, then the window sum ripples down the cell
// chain, one cell per cycle, and then the update.
// One transaction is in flight at a time; the next is taken once the result
// register is empty or being drained.
// Reset (rst, synchronous) empties the record store and the window sum and
// restores the register defaults; record contents are not cleared.
// A stalled output only holds off the next input transaction.
module time_bucket_window_byte_counter #(
  parameter int unsigned DEPTH = 16
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  cfg_we,
  input  wire [tbwc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire [tbwc_pkg::CFG_DATA_W-1:0]       cfg_data,
  tbwc_in_if.sink                              in_ch,
  tbwc_out_if.source                           out_ch
);
  import tbwc_pkg::*;

  localparam int unsigned UW   = $clog2(DEPTH + 1);
  localparam int unsigned CW   = $clog2(DEPTH + 2);
  localparam logic [CW-1:0] SUM_LAST = CW'(DEPTH + 1);

  // configuration registers
  logic [SPAN_W-1:0]  window_span;
  logic [LIMIT_W-1:0] record_limit;

  // control state
  state_t             state, state_next;
  logic [UW-1:0]      used;
  logic [CW-1:0]      sum_cnt;
  logic [BYTES_W-1:0] window_sum;

  // latched transaction
  logic [TAG_W-1:0]   item_bucket;
  logic [CNT_W-1:0]   item_bytes;

  // result register
  logic               out_valid;
  logic [BYTES_W-1:0] out_window;
  logic [USED_W-1:0]  out_used;

  logic               in_ready;
  logic               in_take;
  logic               hit;
  cell_ctrl_t         ctrl;
  logic               sum_done;
  logic [BYTES_W-1:0] final_sum;
  logic [UW-1:0]      keep;
  logic [31:0]        lim;
  logic [31:0]        used_wide;

  record_t            rec_chain [DEPTH+1];
  logic [BYTES_W-1:0] psum      [DEPTH+1];

  assign in_take = in_ch.valid && in_ready;
  // newest record matches the incoming bucket
  assign hit = (used != '0) && (rec_chain[1].tag == in_ch.time_bucket);

  // effective limit: zero acts as one, anything above DEPTH acts as DEPTH
  always_comb begin
    if (record_limit == '0) begin
      lim = 32'd1;
    end else if (32'(record_limit) > 32'(DEPTH)) begin
      lim = 32'(DEPTH);
    end else begin
      lim = 32'(record_limit);
    end
    if (32'(used) >= lim) begin
      keep = UW'(lim - 32'd1);
    end else begin
      keep = used;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_take) begin
          state_next = hit ? ST_FINISH : ST_SHIFT;
        end
      end
      ST_SHIFT:  state_next = ST_SUM;
      ST_SUM: begin
        if (sum_cnt == SUM_LAST) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready   = 1'b0;
    ctrl.shift = 1'b0;
    ctrl.add   = 1'b0;
    sum_done   = 1'b0;
    case (state)
      ST_IDLE:   in_ready   = !out_valid || out_ch.ready;
      ST_SHIFT:  ctrl.shift = 1'b1;
      ST_SUM:    sum_done   = (sum_cnt == SUM_LAST);
      ST_FINISH: ctrl.add   = 1'b1;
      default:   in_ready   = 1'b0;
    endcase
  end

  assign final_sum = sat_add(window_sum, {{(BYTES_W-CNT_W){1'b0}}, item_bytes});

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      used         <= '0;
      sum_cnt      <= '0;
      window_sum   <= '0;
      out_valid    <= 1'b0;
      window_span  <= SPAN_RESET;
      record_limit <= LIMIT_RESET;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        case (cfg_index)
          CFG_WINDOW_SPAN:  window_span  <= cfg_data[SPAN_W-1:0];
          CFG_RECORD_LIMIT: record_limit <= cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end

      if (ctrl.shift) begin
        used    <= keep + UW'(1);
        sum_cnt <= '0;
      end else if (state == ST_SUM) begin
        sum_cnt <= sum_cnt + CW'(1);
      end

      if (sum_done) begin
        window_sum <= psum[DEPTH];
      end else if (ctrl.add) begin
        window_sum <= final_sum;
      end

      if (ctrl.add) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign used_wide = 32'(used);

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_bucket <= in_ch.time_bucket;
      item_bytes  <= in_ch.byte_count;
    end
    if (ctrl.add) begin
      out_window <= final_sum;
      out_used   <= used_wide[USED_W-1:0];
    end
  end

  // cell chain: entry 0 feeds the new record into the front cell
  assign rec_chain[0].tag   = item_bucket;
  assign rec_chain[0].bytes = '0;
  assign psum[0]            = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    tbwc_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .rec_in    (rec_chain[i]),
      .rec_out   (rec_chain[i+1]),
      .held      (used > UW'(i)),
      .bucket    (item_bucket),
      .span      (window_span),
      .add_bytes ((i == 0) ? {{(BYTES_W-CNT_W){1'b0}}, item_bytes} : '0),
      .psum_in   (psum[i]),
      .psum_out  (psum[i+1])
    );
  end

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid;
  assign out_ch.window_bytes = out_window;
  assign out_ch.records_used = out_used;

  // record count stays within the store
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    32'(used) <= 32'(DEPTH))
    else $error("record count exceeds depth");

  // the update cycle always leaves a result behind
  a_finish_out: assert property (@(posedge clk) disable iff (rst)
    state == ST_FINISH |=> out_ch.valid)
    else $error("no result after update");

  // a result is never shown with an empty record store
  a_out_used: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> used != '0)
    else $error("result with no records held");

  // nothing is accepted while an item is in flight
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHIFT || state == ST_SUM) |-> !in_ready)
    else $error("input accepted mid-update");

endmodule
`default_nettype wire
